>>> hw/rtl/delta_timer_queue_macros.svh
// Assertion macros used by the delta timer queue top level.
`ifndef DELTA_TIMER_QUEUE_MACROS_SVH
`define DELTA_TIMER_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_CLK(lbl, c, r, p, m) \
  lbl: assert property (@(posedge c) disable iff (r) p) else $error(m);

// Concurrent assertion on the block clock clk and reset rst.
`define ASSERT_STD(lbl, p, m) \
  `ASSERT_CLK(lbl, clk, rst, p, m)

`else

`define ASSERT_CLK(lbl, c, r, p, m)
`define ASSERT_STD(lbl, p, m)

`endif

`endif

>>> hw/rtl/dtq_pkg.sv
// Types, constants and codes of the delta timer queue.
`default_nettype none

package dtq_pkg;

  // Number of processes, one timer entry each.
  localparam int PROC_COUNT  = 16;
  // Most expiries reported for one tick.
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W   = $clog2(PROC_COUNT);
  localparam int LINK_W  = $clog2(PROC_COUNT + 1);
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int PID_W   = 4;
  localparam int DELTA_W = 16;
  localparam int TPS_W   = 16;

  // Link value that ends the list and marks an empty queue.
  localparam logic [LINK_W-1:0] NIL = LINK_W'(PROC_COUNT);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RESULTS);
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(60);

  // Input command codes.
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // Result kind codes.
  localparam logic [1:0] KIND_ACK       = 2'd0;
  localparam logic [1:0] KIND_EXPIRED   = 2'd1;
  localparam logic [1:0] KIND_IDLE_TICK = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LINK,
    ST_SPLICE,
    ST_DEC,
    ST_EXP,
    ST_EMIT
  } state_t;

  // One write into the entry store; all enabled fields share the address.
  typedef struct packed {
    logic               delta_we;
    logic               link_we;
    logic               pend_we;
    logic [IDX_W-1:0]   addr;
    logic [DELTA_W-1:0] delta;
    logic [LINK_W-1:0]  link;
    logic               pend;
  } dtq_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/dtq_store.sv
// Entry store of the timer queue: delta, link and pending flag per process.
`default_nettype none

module dtq_store
  import dtq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dtq_wr_t               wr,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output logic      [DELTA_W-1:0]    rd_delta,
  output logic      [LINK_W-1:0]     rd_link,
  output logic      [PROC_COUNT-1:0] pending
);

  logic [DELTA_W-1:0] delta_mem [PROC_COUNT];
  logic [LINK_W-1:0]  link_mem  [PROC_COUNT];

  // Delta and link entries hold no reset; they are read only after an insert.
  always_ff @(posedge clk) begin
    if (wr.delta_we) begin
      delta_mem[wr.addr] <= wr.delta;
    end
    if (wr.link_we) begin
      link_mem[wr.addr] <= wr.link;
    end
  end

  // Pending flags clear at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (wr.pend_we) begin
      pending[wr.addr] <= wr.pend;
    end
  end

  // Single read port at the entry the sequencer is looking at.
  assign rd_delta = delta_mem[rd_addr];
  assign rd_link  = link_mem[rd_addr];

endmodule

`default_nettype wire

>>> hw/rtl/delta_timer_queue.sv
// Top level of the delta timer queue: sequencer, prescaler and result register.
//
// Input stream (s_*): s_tuser is the command (0 raw tick, 1 insert), s_tdata
// carries proc_id and delay. One request is taken at a time; s_tready is high
// only while the sequencer is idle.
// Output stream (m_*): one result register. m_tuser is the result kind,
// m_tdata carries the process and the status, m_tlast marks the final result
// of a request.
// Configuration (cfg_*): ticks_per_second, always ready, to be written by the user only while idle (unchecked).
// Sequence: an insert passes one list entry per cycle until it finds its place,
// then writes the new entry, links it in and loads its acknowledgement. A
// rejected insert loads its acknowledgement directly. A tick lowers the head
// delta on a full second, then unlinks each expired timer and loads its result,
// or loads an idle-tick result when none expires. The next request is taken the
// cycle after the final result is loaded. The entry store has a single read
// port.
// Reset empties the queue, clears all pending flags and the prescaler, and
// sets ticks_per_second to 60. When the receiver stalls, the sequencer holds
// its next result and waits; no result is dropped.
`default_nettype none

`include "delta_timer_queue_macros.svh"

module delta_timer_queue
  import dtq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Requests in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [3:0] proc_id, [19:4] delay, [23:20] zero
  input  wire logic        s_tuser,   // [0] command
  // Results out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // [3:0] done_proc, [4] status, [7:5] zero
  output logic      [1:0]  m_tuser,   // [1:0] kind
  output logic             m_tlast,   // last
  // Configuration write.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // ticks_per_second
);

  state_t state, state_next;

  logic [PID_W-1:0]   pid, pid_next;
  logic [DELTA_W-1:0] remain, remain_next;
  logic [LINK_W-1:0]  cur, cur_next;
  logic [LINK_W-1:0]  prev, prev_next;
  logic [LINK_W-1:0]  queue_head, queue_head_next;
  logic [TPS_W-1:0]   sub_count, sub_count_next;
  logic [TPS_W-1:0]   tps;
  logic               held, held_next;
  logic [CNT_W-1:0]   exp_count, exp_count_next;

  logic [1:0]       res_kind, res_kind_next;
  logic [PID_W-1:0] res_proc, res_proc_next;
  logic             res_status, res_status_next;
  logic             res_last, res_last_next;
  state_t           res_ret, res_ret_next;

  logic [PID_W-1:0] m_proc;
  logic             m_status;
  logic             out_load;

  dtq_wr_t             wr;
  logic [IDX_W-1:0]    rd_addr;
  logic [DELTA_W-1:0]  rd_delta;
  logic [LINK_W-1:0]   rd_link;
  logic [PROC_COUNT-1:0] pending;

  logic               in_cmd;
  logic [PID_W-1:0]   in_pid;
  logic [DELTA_W-1:0] in_delay;
  logic               in_range;
  logic [IDX_W-1:0]   pid_idx;
  logic [TPS_W-1:0]   limit;
  logic [TPS_W:0]     sub_inc;
  logic               expire_ok;

  // Request fields.
  assign in_cmd   = s_tuser;
  assign in_pid   = s_tdata[3:0];
  assign in_delay = s_tdata[19:4];
  assign in_range = (int'(in_pid) < PROC_COUNT);
  assign pid_idx  = IDX_W'(pid);

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Prescaler compare: a limit of zero counts as one.
  assign limit   = (tps == '0) ? TPS_W'(1) : tps;
  assign sub_inc = {1'b0, sub_count} + (TPS_W + 1)'(1);

  // The walk reads the current entry; every other state reads the head.
  assign rd_addr = (state == ST_WALK) ? cur[IDX_W-1:0] : queue_head[IDX_W-1:0];

  // The head expires when it is present, at zero, and the tick has room left.
  assign expire_ok = (exp_count < MAX_CNT) && (queue_head != NIL) && (rd_delta == '0);

  dtq_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_delta (rd_delta),
    .rd_link  (rd_link),
    .pending  (pending)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, datapath updates and store writes.
  always_comb begin
    state_next      = state;
    pid_next        = pid;
    remain_next     = remain;
    cur_next        = cur;
    prev_next       = prev;
    queue_head_next = queue_head;
    sub_count_next  = sub_count;
    held_next       = held;
    exp_count_next  = exp_count;
    res_kind_next   = res_kind;
    res_proc_next   = res_proc;
    res_status_next = res_status;
    res_last_next   = res_last;
    res_ret_next    = res_ret;
    out_load        = 1'b0;
    wr              = '0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_cmd == CMD_INSERT) begin
            pid_next = in_pid;
            if (!in_range || pending[IDX_W'(in_pid)]) begin
              res_kind_next   = KIND_ACK;
              res_proc_next   = in_pid;
              res_status_next = STATUS_REJECT;
              res_last_next   = 1'b1;
              res_ret_next    = ST_IDLE;
              state_next      = ST_EMIT;
            end else begin
              remain_next = (in_delay == '0) ? DELTA_W'(1) : in_delay;
              prev_next   = NIL;
              cur_next    = queue_head;
              state_next  = ST_WALK;
            end
          end else begin
            held_next      = 1'b0;
            exp_count_next = '0;
            if (sub_inc >= {1'b0, limit}) begin
              sub_count_next = '0;
              state_next     = ST_DEC;
            end else begin
              sub_count_next = sub_inc[TPS_W-1:0];
              state_next     = ST_EXP;
            end
          end
        end
      end

      // One list entry per cycle: stop in front of the first larger delta.
      ST_WALK: begin
        if (cur == NIL) begin
          state_next = ST_LINK;
        end else if (remain < rd_delta) begin
          wr.delta_we = 1'b1;
          wr.addr     = cur[IDX_W-1:0];
          wr.delta    = rd_delta - remain;
          state_next  = ST_LINK;
        end else begin
          remain_next = remain - rd_delta;
          prev_next   = cur;
          cur_next    = rd_link;
        end
      end

      // Write the new entry itself.
      ST_LINK: begin
        wr.delta_we = 1'b1;
        wr.link_we  = 1'b1;
        wr.pend_we  = 1'b1;
        wr.addr     = pid_idx;
        wr.delta    = remain;
        wr.link     = cur;
        wr.pend     = 1'b1;
        state_next  = ST_SPLICE;
      end

      // Point the predecessor, or the head, at the new entry.
      ST_SPLICE: begin
        if (prev != NIL) begin
          wr.link_we = 1'b1;
          wr.addr    = prev[IDX_W-1:0];
          wr.link    = LINK_W'(pid_idx);
        end else begin
          queue_head_next = LINK_W'(pid_idx);
        end
        res_kind_next   = KIND_ACK;
        res_proc_next   = pid;
        res_status_next = STATUS_OK;
        res_last_next   = 1'b1;
        res_ret_next    = ST_IDLE;
        state_next      = ST_EMIT;
      end

      // A full second lowers the head delta.
      ST_DEC: begin
        if (queue_head != NIL && rd_delta != '0) begin
          wr.delta_we = 1'b1;
          wr.addr     = queue_head[IDX_W-1:0];
          wr.delta    = rd_delta - DELTA_W'(1);
        end
        state_next = ST_EXP;
      end

      // Unlink expired heads; a held result goes out once the next is known.
      ST_EXP: begin
        if (expire_ok) begin
          if (held) begin
            res_last_next = 1'b0;
            res_ret_next  = ST_EXP;
            held_next     = 1'b0;
            state_next    = ST_EMIT;
          end else begin
            wr.pend_we      = 1'b1;
            wr.addr         = queue_head[IDX_W-1:0];
            wr.pend         = 1'b0;
            res_kind_next   = KIND_EXPIRED;
            res_proc_next   = PID_W'(queue_head[IDX_W-1:0]);
            res_status_next = STATUS_OK;
            queue_head_next = (rd_link > NIL) ? NIL : rd_link;
            exp_count_next  = exp_count + CNT_W'(1);
            held_next       = 1'b1;
          end
        end else begin
          if (!held) begin
            res_kind_next   = KIND_IDLE_TICK;
            res_proc_next   = '0;
            res_status_next = STATUS_OK;
          end
          held_next     = 1'b0;
          res_last_next = 1'b1;
          res_ret_next  = ST_IDLE;
          state_next    = ST_EMIT;
        end
      end

      // Move the pending result into the output register once it is free.
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = res_ret;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head <= NIL;
      sub_count  <= '0;
      held       <= 1'b0;
      exp_count  <= '0;
    end else begin
      queue_head <= queue_head_next;
      sub_count  <= sub_count_next;
      held       <= held_next;
      exp_count  <= exp_count_next;
    end
  end

  // Datapath and pending-result registers.
  always_ff @(posedge clk) begin
    pid        <= pid_next;
    remain     <= remain_next;
    cur        <= cur_next;
    prev       <= prev_next;
    res_kind   <= res_kind_next;
    res_proc   <= res_proc_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
    res_ret    <= res_ret_next;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tps <= cfg_data;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser  <= res_kind;
      m_proc   <= res_proc;
      m_status <= res_status;
      m_tlast  <= res_last;
    end
  end

  assign m_tdata = {3'b000, m_status, m_proc};

  // Every accepted request leaves the idle state.
  `ASSERT_STD(a_accept_leaves_idle, (s_tvalid && s_tready) |=> (state != ST_IDLE), "request accepted but sequencer stayed idle")

  // The walk never meets the entry that is being inserted.
  `ASSERT_STD(a_walk_not_self, (state == ST_WALK && cur != NIL) |-> (cur[IDX_W-1:0] != pid_idx), "insert walk reached its own entry")

  // One tick never reports more expiries than allowed.
  `ASSERT_STD(a_expiry_bound, (state == ST_EXP) |-> (exp_count <= MAX_CNT), "too many expiries in one tick")

  // The output register is only reloaded when it is free.
  `ASSERT_STD(a_no_overwrite, (m_tvalid && !m_tready) |-> !out_load, "result overwritten while stalled")

endmodule

`default_nettype wire
